### hw/rtl/vslp_pkg.sv
package vslp_pkg;

	localparam int CoordXyBits = 6;
	localparam int CoordZBits  = 5;
	localparam int HalfBits    = 6;
	localparam int InLabelBits = 16;
	localparam int ClassBits   = 16;
	localparam int SizeXyBits  = 7;
	localparam int SizeZBits   = 6;
	localparam int CfgIdxBits  = 3;

	localparam logic [15:0] CLASS_SCALE = 16'd10000;

	localparam logic [ClassBits-1:0]  CLASS_LOW_RST   = 16'd100;
	localparam logic [ClassBits-1:0]  CLASS_HIGH_RST  = 16'd6000;
	localparam logic [SizeXyBits-1:0] SIZE_X_RST      = 7'd64;
	localparam logic [SizeXyBits-1:0] SIZE_Y_RST      = 7'd64;
	localparam logic [SizeZBits-1:0]  SIZE_Z_RST      = 6'd32;

	typedef enum logic [CfgIdxBits-1:0] {
		REG_CLASS_LOW   = 3'd0,
		REG_CLASS_HIGH  = 3'd1,
		REG_EXTENT_MODE = 3'd2,
		REG_SIZE_X      = 3'd3,
		REG_SIZE_Y      = 3'd4,
		REG_SIZE_Z      = 3'd5
	} vslp_reg_t;

	typedef enum logic {
		OP_PAINT = 1'b0,
		OP_READ  = 1'b1
	} vslp_op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SXY,
		ST_RD_ROW,
		ST_RD_ADDR,
		ST_RD_MEM,
		ST_RD_DATA,
		ST_HXY,
		ST_VOL,
		ST_LO,
		ST_HI,
		ST_R2,
		ST_GATE,
		ST_EX2,
		ST_Z,
		ST_ZSQ,
		ST_Y,
		ST_YSQ,
		ST_X,
		ST_RESULT
	} vslp_state_t;

	typedef struct packed {
		logic                   operation;
		logic [CoordXyBits-1:0] center_x;
		logic [CoordXyBits-1:0] center_y;
		logic [CoordZBits-1:0]  center_z;
		logic [HalfBits-1:0]    half_x;
		logic [HalfBits-1:0]    half_y;
		logic [HalfBits-1:0]    half_z;
		logic [HalfBits-1:0]    radius;
		logic [InLabelBits-1:0] label;
		logic [CoordXyBits-1:0] voxel_x;
		logic [CoordXyBits-1:0] voxel_y;
		logic [CoordZBits-1:0]  voxel_z;
	} vslp_in_t;

	typedef struct packed {
		logic                   was_read;
		logic [InLabelBits-1:0] read_value;
		logic                   painted;
	} vslp_out_t;

endpackage

### hw/rtl/vslp_stream_if.sv
interface vslp_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/vslp_vol_mem.sv
module vslp_vol_mem #(
	parameter int DEPTH = 131072,
	parameter int AW    = 17,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

### hw/rtl/voxel_sphere_label_painter.sv
// Voxel sphere label painter.
// req carries paint and read items, rsp returns one result per item; an item
// transfers when valid and ready are both high. Configuration is a plain
// write port (cfg_wr_en, cfg_index, cfg_data), to be written only while idle;
// the block does not enforce this. After reset the label volume is swept to
// zero, one voxel a cycle over MAX_X*MAX_Y*MAX_Z voxels; req is not ready then.
// The block works on one item at a time; all products come from one shared
// 16x16 multiplier driven by the sequencer.
// A read steps through ST_SXY, ST_RD_ROW, ST_RD_ADDR, ST_RD_MEM and
// ST_RD_DATA to ST_RESULT. A paint runs ST_SXY to ST_R2 for the size
// gate (ST_GATE) and, if it passes, ST_EX2, then ST_Z per slice of the
// box, ST_ZSQ per slice passing z_ok, ST_Y per row, ST_YSQ per row inside
// the volume and ST_X per voxel of those rows, writing one voxel a cycle.
// The result sits in an output register; req is ready again as soon as the
// result is loaded, so the next item runs while rsp is stalled. A finished
// item waits only if the previous result has not been taken yet.
module voxel_sphere_label_painter #(
	parameter int MAX_X      = 64,
	parameter int MAX_Y      = 64,
	parameter int MAX_Z      = 32,
	parameter int LABEL_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	vslp_stream_if.sink                   req,
	vslp_stream_if.source                 rsp,
	input  logic                          cfg_wr_en,
	input  logic [vslp_pkg::CfgIdxBits-1:0] cfg_index,
	input  logic [vslp_pkg::ClassBits-1:0]  cfg_data
);
	import vslp_pkg::*;

	localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
	localparam int AW    = $clog2(DEPTH);

	vslp_state_t state_q, state_d;

	logic [ClassBits-1:0]  class_low_q, class_high_q;
	logic                  extent_mode_q;
	logic [SizeXyBits-1:0] size_x_q, size_y_q;
	logic [SizeZBits-1:0]  size_z_q;

	logic [SizeXyBits-1:0] sx, sy;
	logic [SizeZBits-1:0]  sz;

	vslp_in_t  item_q;
	vslp_out_t out_q;
	logic      out_valid_q;
	logic      pend_read_q, pend_paint_q;
	logic [InLabelBits-1:0] pend_val_q;

	logic [AW-1:0] clr_q;
	logic [AW-1:0] acc_q, rd_addr_q, zb_q, row_q;
	logic          inr_q;
	logic [13:0]   sxy_q;
	logic [17:0]   vol_q;
	logic [29:0]   lo_thr_q, hi_thr_q;
	logic [11:0]   r2_q, ex2_q, dz2_q;
	logic [12:0]   dyz2_q, dx2_q;
	logic [HalfBits-1:0] ex_q, ey_q, ez_q;
	logic [HalfBits-1:0] dz_abs_q, dy_abs_q;
	logic [6:0]    wx_q, wy_q, wz_q;
	logic signed [9:0] x_q;
	logic signed [7:0] dx_q;

	logic [15:0] mul_a, mul_b;
	logic [31:0] mul_p;

	logic signed [9:0] z_c, y_c, dz_c, dy_c;
	logic [9:0]        dz_mag, dy_mag;
	logic              z_ok, y_ok, x_ok, gate_ok, in_sphere;
	logic [30:0]       scaled;
	logic [13:0]       dist2;
	logic signed [15:0] dx2_nx;

	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_waddr;
	logic [LABEL_BITS-1:0] mem_wdata, mem_rdata, lab;
	logic                  load_out;

	// saturated sizes
	assign sx = (int'(size_x_q) > MAX_X) ? SizeXyBits'(MAX_X) : size_x_q;
	assign sy = (int'(size_y_q) > MAX_Y) ? SizeXyBits'(MAX_Y) : size_y_q;
	assign sz = (int'(size_z_q) > MAX_Z) ? SizeZBits'(MAX_Z) : size_z_q;

	assign mul_p = mul_a * mul_b;

	assign lab = LABEL_BITS'(item_q.label);

	assign z_c = $signed({5'b0, item_q.center_z}) - $signed({4'b0, ez_q})
		+ $signed({3'b0, wz_q});
	assign y_c = $signed({4'b0, item_q.center_y}) - $signed({4'b0, ey_q})
		+ $signed({3'b0, wy_q});
	assign dz_c = z_c - $signed({5'b0, item_q.center_z});
	assign dy_c = y_c - $signed({4'b0, item_q.center_y});
	assign dz_mag = dz_c[9] ? 10'(-dz_c) : 10'(dz_c);
	assign dy_mag = dy_c[9] ? 10'(-dy_c) : 10'(dy_c);

	assign z_ok = (z_c > 10'sd0)
		&& (z_c + $signed({4'b0, ez_q}) <= $signed({4'b0, sz}));
	assign y_ok = (y_c >= 10'sd0) && (y_c < $signed({3'b0, sy}));
	assign x_ok = (x_q >= 10'sd0) && (x_q < $signed({3'b0, sx}));

	assign scaled  = {vol_q, 13'b0};
	assign gate_ok = ({1'b0, scaled} > {2'b0, lo_thr_q})
		&& ({1'b0, scaled} < {2'b0, hi_thr_q});

	assign dist2     = {1'b0, dyz2_q} + {1'b0, dx2_q};
	assign in_sphere = dist2 < {2'b0, r2_q};
	assign dx2_nx    = $signed({3'b0, dx2_q}) + $signed({{7{dx_q[7]}}, dx_q, 1'b0})
		+ 16'sd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_low_q   <= CLASS_LOW_RST;
			class_high_q  <= CLASS_HIGH_RST;
			extent_mode_q <= 1'b0;
			size_x_q      <= SIZE_X_RST;
			size_y_q      <= SIZE_Y_RST;
			size_z_q      <= SIZE_Z_RST;
		end else if (cfg_wr_en) begin
			case (vslp_reg_t'(cfg_index))
				REG_CLASS_LOW:   class_low_q   <= cfg_data;
				REG_CLASS_HIGH:  class_high_q  <= cfg_data;
				REG_EXTENT_MODE: extent_mode_q <= cfg_data[0];
				REG_SIZE_X:      size_x_q      <= cfg_data[SizeXyBits-1:0];
				REG_SIZE_Y:      size_y_q      <= cfg_data[SizeXyBits-1:0];
				REG_SIZE_Z:      size_z_q      <= cfg_data[SizeZBits-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		mem_we    = 1'b0;
		mem_waddr = row_q + AW'($unsigned(x_q));
		mem_wdata = in_sphere ? lab : '0;
		mem_re    = 1'b0;
		load_out  = 1'b0;
		req.ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_SXY;
				end
			end
			ST_SXY: begin
				mul_a = {9'b0, sx};
				mul_b = {9'b0, sy};
				state_d = (vslp_op_t'(item_q.operation) == OP_READ) ? ST_RD_ROW : ST_HXY;
			end
			ST_RD_ROW: begin
				mul_a = {9'b0, sx};
				mul_b = {10'b0, item_q.voxel_y};
				state_d = ST_RD_ADDR;
			end
			ST_RD_ADDR: begin
				mul_a = {2'b0, sxy_q};
				mul_b = {11'b0, item_q.voxel_z};
				state_d = ST_RD_MEM;
			end
			ST_RD_MEM: begin
				mem_re  = 1'b1;
				state_d = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				state_d = ST_RESULT;
			end
			ST_HXY: begin
				mul_a = {10'b0, item_q.half_x};
				mul_b = {10'b0, item_q.half_y};
				state_d = ST_VOL;
			end
			ST_VOL: begin
				mul_a = {4'b0, vol_q[11:0]};
				mul_b = {10'b0, item_q.half_z};
				state_d = ST_LO;
			end
			ST_LO: begin
				mul_a = class_low_q;
				mul_b = CLASS_SCALE;
				state_d = ST_HI;
			end
			ST_HI: begin
				mul_a = class_high_q;
				mul_b = CLASS_SCALE;
				state_d = ST_R2;
			end
			ST_R2: begin
				mul_a = {10'b0, item_q.radius};
				mul_b = {10'b0, item_q.radius};
				state_d = ST_GATE;
			end
			ST_GATE: begin
				state_d = gate_ok ? ST_EX2 : ST_RESULT;
			end
			ST_EX2: begin
				mul_a = {10'b0, ex_q};
				mul_b = {10'b0, ex_q};
				state_d = ST_Z;
			end
			ST_Z: begin
				mul_a = {2'b0, sxy_q};
				mul_b = {10'b0, z_c[5:0]};
				if (wz_q >= {ez_q, 1'b0}) begin
					state_d = ST_RESULT;
				end else if (z_ok) begin
					state_d = ST_ZSQ;
				end
			end
			ST_ZSQ: begin
				mul_a = {10'b0, dz_abs_q};
				mul_b = {10'b0, dz_abs_q};
				state_d = ST_Y;
			end
			ST_Y: begin
				mul_a = {9'b0, sx};
				mul_b = {9'b0, y_c[6:0]};
				if (wy_q >= {ey_q, 1'b0}) begin
					state_d = ST_Z;
				end else if (y_ok) begin
					state_d = ST_YSQ;
				end
			end
			ST_YSQ: begin
				mul_a = {10'b0, dy_abs_q};
				mul_b = {10'b0, dy_abs_q};
				state_d = ST_X;
			end
			ST_X: begin
				if (wx_q >= {ex_q, 1'b0}) begin
					state_d = ST_Y;
				end else begin
					mem_we = x_ok;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
			pend_read_q  <= 1'b0;
			pend_paint_q <= 1'b0;
			wx_q         <= '0;
			wy_q         <= '0;
			wz_q         <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_RD_DATA: begin
					pend_read_q  <= 1'b1;
					pend_paint_q <= 1'b0;
				end
				ST_GATE: begin
					pend_read_q  <= 1'b0;
					pend_paint_q <= gate_ok;
					wz_q         <= '0;
				end
				ST_Z: begin
					if (wz_q >= {ez_q, 1'b0}) begin
						wz_q <= '0;
					end else if (!z_ok) begin
						wz_q <= wz_q + 7'd1;
					end
					wy_q <= '0;
				end
				ST_Y: begin
					if (wy_q >= {ey_q, 1'b0}) begin
						wy_q <= '0;
						wz_q <= wz_q + 7'd1;
					end else if (!y_ok) begin
						wy_q <= wy_q + 7'd1;
					end
				end
				ST_YSQ: wx_q <= '0;
				ST_X: begin
					if (wx_q >= {ex_q, 1'b0}) begin
						wx_q <= '0;
						wy_q <= wy_q + 7'd1;
					end else begin
						wx_q <= wx_q + 7'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_q <= req.data;
		end
		if (load_out) begin
			out_q.was_read   <= pend_read_q;
			out_q.read_value <= pend_val_q;
			out_q.painted    <= pend_paint_q;
		end
		case (state_q)
			ST_SXY:     sxy_q <= mul_p[13:0];
			ST_RD_ROW: begin
				acc_q <= AW'(mul_p) + AW'(item_q.voxel_x);
				inr_q <= ({1'b0, item_q.voxel_x} < sx) && ({1'b0, item_q.voxel_y} < sy)
					&& ({1'b0, item_q.voxel_z} < sz);
			end
			ST_RD_ADDR: rd_addr_q <= acc_q + AW'(mul_p);
			ST_RD_DATA: pend_val_q <= inr_q ? InLabelBits'(mem_rdata) : '0;
			ST_HXY:     vol_q <= mul_p[17:0];
			ST_VOL:     vol_q <= mul_p[17:0];
			ST_LO:      lo_thr_q <= mul_p[29:0];
			ST_HI:      hi_thr_q <= mul_p[29:0];
			ST_R2:      r2_q <= mul_p[11:0];
			ST_GATE: begin
				pend_val_q <= '0;
				ex_q <= extent_mode_q ? item_q.radius : item_q.half_x;
				ey_q <= extent_mode_q ? item_q.radius : item_q.half_y;
				ez_q <= extent_mode_q ? item_q.radius : item_q.half_z;
			end
			ST_EX2:     ex2_q <= mul_p[11:0];
			ST_Z: begin
				zb_q     <= AW'(mul_p);
				dz_abs_q <= dz_mag[HalfBits-1:0];
			end
			ST_ZSQ:     dz2_q <= mul_p[11:0];
			ST_Y: begin
				row_q    <= zb_q + AW'(mul_p);
				dy_abs_q <= dy_mag[HalfBits-1:0];
			end
			ST_YSQ: begin
				dyz2_q <= {1'b0, dz2_q} + 13'(mul_p[11:0]);
				x_q    <= $signed({4'b0, item_q.center_x}) - $signed({4'b0, ex_q});
				dx_q   <= -$signed({2'b0, ex_q});
				dx2_q  <= {1'b0, ex2_q};
			end
			ST_X: begin
				x_q   <= x_q + 10'sd1;
				dx_q  <= dx_q + 8'sd1;
				dx2_q <= 13'(dx2_nx);
			end
			default: ;
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	vslp_vol_mem #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.DW   (LABEL_BITS)
	) u_vol_mem (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_en  (mem_re),
		.rd_addr(rd_addr_q),
		.rd_data(mem_rdata)
	);

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_X))
		else $error("volume write outside clear or walk");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.was_read) |-> !rsp.data.painted)
		else $error("read result flagged as painted");

	a_paint_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.data.was_read) |-> (rsp.data.read_value == '0))
		else $error("paint result carries a value");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_SXY))
		else $error("transfer did not start sequencer");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_X) |-> (wx_q <= {ex_q, 1'b0}))
		else $error("x walk overran box");
endmodule
